>>> sv/crast_pkg.sv
`default_nettype none

package crast_pkg;

   // Default coordinate width of the center and radius fields.
   localparam int COORD_BITS_DEFAULT = 10;

   // Midpoint decision constants.
   localparam int INIT_BIAS      = 3;
   localparam int STEP_BIAS_DIAG = 10;
   localparam int STEP_BIAS_AXIS = 6;

   // Operation codes of an input beat.
   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

endpackage

`default_nettype wire

>>> sv/crast_req_if.sv
`default_nettype none

interface crast_req_if #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-1:0] radius;

   modport source (output valid, operation, center_x, center_y, radius, input ready);
   modport sink   (input valid, operation, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

>>> sv/crast_rsp_if.sv
`default_nettype none

interface crast_rsp_if #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS+1:0] pixel_x;
   logic signed [COORD_BITS+1:0] pixel_y;
   logic                         pixel_valid;
   logic                         run_last;
   logic                         circle_done;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, run_last, circle_done,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_valid, run_last, circle_done,
                   output ready);
endinterface

`default_nettype wire

>>> sv/circle_rasterizer.sv
`default_nettype none

// Midpoint circle generator. A start beat latches the center and radius and
// produces the eight mirror pixels of (0, r); each advance beat moves one point
// along the octant and produces its eight mirror pixels, the last one flagged
// circle_done once the octant is finished. An advance while no circle is running
// produces a single beat with pixel_valid low. The point update happens in the
// cycle an input beat is accepted; the pixels then leave through a registered
// output at one beat per cycle while the receiver is ready. The next input beat is
// accepted in the cycle the last pixel of the current point is loaded into the
// output register, so points stream without gaps.

module circle_rasterizer #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   crast_req_if.sink   req_chan,
   crast_rsp_if.source rsp_chan
);
   import crast_pkg::*;

   localparam int POS_BITS = COORD_BITS + 1;
   localparam int DEC_BITS = COORD_BITS + 6;
   localparam int PIX_BITS = COORD_BITS + 2;

   // Generator state.
   logic signed [POS_BITS-1:0]   step_x_ff, step_x_in;
   logic signed [POS_BITS-1:0]   step_y_ff, step_y_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic [COORD_BITS-1:0]        held_cx_ff, held_cx_in;
   logic [COORD_BITS-1:0]        held_cy_ff, held_cy_in;
   logic                         active_ff, active_in;

   // Pixel sequencer for the current point.
   logic                         busy_ff, busy_in;
   logic [2:0]                   idx_ff, idx_in;
   logic                         blank_ff, blank_in;
   logic                         done_pend_ff, done_pend_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_BITS-1:0]   pix_x_ff, pix_x_in;
   logic signed [PIX_BITS-1:0]   pix_y_ff, pix_y_in;
   logic                         pix_valid_ff, pix_valid_in;
   logic                         last_ff, last_in;
   logic                         done_ff, done_in;

   logic                         load;
   logic                         last_pix;
   logic                         accept;
   logic                         is_start;

   // Point update terms.
   logic signed [POS_BITS-1:0]   adv_x;
   logic signed [POS_BITS-1:0]   adv_y;
   logic signed [DEC_BITS-1:0]   adv_x_ext;
   logic signed [DEC_BITS-1:0]   adv_y_ext;
   logic signed [DEC_BITS-1:0]   adv_dec;
   logic                         dec_positive;

   // Mirror terms.
   logic signed [POS_BITS-1:0]   mir_a;
   logic signed [POS_BITS-1:0]   mir_b;
   logic signed [PIX_BITS-1:0]   mir_a_ext;
   logic signed [PIX_BITS-1:0]   mir_b_ext;
   logic signed [PIX_BITS-1:0]   off_x;
   logic signed [PIX_BITS-1:0]   off_y;

   // Handshake control.
   assign load     = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign last_pix = blank_ff || (idx_ff == 3'd7);
   assign req_chan.ready = !busy_ff || (load && last_pix);
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_start = (req_chan.operation == OP_START);

   // One midpoint step from the current point.
   always_comb begin
      dec_positive = !decision_ff[DEC_BITS-1] && (|decision_ff);
      adv_x        = step_x_ff + POS_BITS'(1);
      adv_y        = dec_positive ? (step_y_ff - POS_BITS'(1)) : step_y_ff;
      adv_x_ext    = {{(DEC_BITS-POS_BITS){adv_x[POS_BITS-1]}}, adv_x};
      adv_y_ext    = {{(DEC_BITS-POS_BITS){adv_y[POS_BITS-1]}}, adv_y};
      if (dec_positive) begin
         adv_dec = decision_ff + ((adv_x_ext - adv_y_ext) <<< 2)
                   + DEC_BITS'(STEP_BIAS_DIAG);
      end else begin
         adv_dec = decision_ff + (adv_x_ext <<< 2) + DEC_BITS'(STEP_BIAS_AXIS);
      end
   end

   // Next generator state on an accepted beat.
   always_comb begin
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      decision_in  = decision_ff;
      held_cx_in   = held_cx_ff;
      held_cy_in   = held_cy_ff;
      active_in    = active_ff;
      blank_in     = blank_ff;
      done_pend_in = done_pend_ff;
      if (accept) begin
         if (is_start) begin
            step_x_in    = '0;
            step_y_in    = {1'b0, req_chan.radius};
            decision_in  = DEC_BITS'(INIT_BIAS)
                           - {{(DEC_BITS-COORD_BITS-1){1'b0}}, req_chan.radius, 1'b0};
            held_cx_in   = req_chan.center_x;
            held_cy_in   = req_chan.center_y;
            active_in    = 1'b1;
            blank_in     = 1'b0;
            done_pend_in = 1'b0;
         end else if (!active_ff) begin
            blank_in     = 1'b1;
            done_pend_in = 1'b1;
         end else begin
            step_x_in    = adv_x;
            step_y_in    = adv_y;
            decision_in  = adv_dec;
            blank_in     = 1'b0;
            done_pend_in = (adv_x > adv_y);
            active_in    = !(adv_x > adv_y);
         end
      end
   end

   // Sequencer: eight pixels per point, one for a blank beat.
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (accept) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (load) begin
         idx_in = idx_ff + 3'd1;
         if (last_pix) begin
            busy_in = 1'b0;
         end
      end
   end

   // Mirror selection: bit 2 swaps the axes, bits 0 and 1 negate them.
   always_comb begin
      mir_a     = idx_ff[2] ? step_y_ff : step_x_ff;
      mir_b     = idx_ff[2] ? step_x_ff : step_y_ff;
      mir_a_ext = {{(PIX_BITS-POS_BITS){mir_a[POS_BITS-1]}}, mir_a};
      mir_b_ext = {{(PIX_BITS-POS_BITS){mir_b[POS_BITS-1]}}, mir_b};
      off_x     = idx_ff[0] ? -mir_a_ext : mir_a_ext;
      off_y     = idx_ff[1] ? -mir_b_ext : mir_b_ext;
   end

   // Output register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_valid_in = pix_valid_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (blank_ff) begin
            pix_x_in     = '0;
            pix_y_in     = '0;
            pix_valid_in = 1'b0;
            last_in      = 1'b1;
            done_in      = 1'b1;
         end else begin
            pix_x_in     = {2'b00, held_cx_ff} + off_x;
            pix_y_in     = {2'b00, held_cy_ff} + off_y;
            pix_valid_in = 1'b1;
            last_in      = (idx_ff == 3'd7);
            done_in      = (idx_ff == 3'd7) && done_pend_ff;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         decision_ff  <= '0;
         held_cx_ff   <= '0;
         held_cy_ff   <= '0;
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         blank_ff     <= 1'b0;
         done_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         decision_ff  <= decision_in;
         held_cx_ff   <= held_cx_in;
         held_cy_ff   <= held_cy_in;
         active_ff    <= active_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         blank_ff     <= blank_in;
         done_pend_ff <= done_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_valid_ff <= pix_valid_in;
      last_ff      <= last_in;
      done_ff      <= done_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = pix_x_ff;
   assign rsp_chan.pixel_y     = pix_y_ff;
   assign rsp_chan.pixel_valid = pix_valid_ff;
   assign rsp_chan.run_last    = last_ff;
   assign rsp_chan.circle_done = done_ff;

endmodule

`default_nettype wire

>>> bench/crast_checker.sv
`default_nettype none

// Watches both channels of the circle generator, traces the midpoint circle
// on its own and compares every pixel beat with the oldest predicted one.
module crast_checker #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEFAULT
) (
   input  wire  clock,
   input  wire  reset,
   crast_req_if req_mon,
   crast_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import crast_pkg::*;

   localparam int PIX_W = COORD_BITS + 2;
   localparam int POS_W = COORD_BITS + 1;
   localparam int DEC_W = COORD_BITS + 6;

   typedef struct {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    pixel_valid;
      logic                    run_last;
      logic                    circle_done;
   } pixel_beat_type;

   // Predicted pixel beats, oldest first.
   pixel_beat_type pixel_queue[$];

   // Own copy of the generator state.
   logic signed [POS_W-1:0] trace_x;
   logic signed [POS_W-1:0] trace_y;
   logic signed [DEC_W-1:0] trace_decision;
   logic [COORD_BITS-1:0]   held_cx;
   logic [COORD_BITS-1:0]   held_cy;
   logic                    tracing;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void push_pixel(input int px, input int py, input logic pv,
                                      input logic last, input logic done);
      pixel_beat_type beat;
      beat.pixel_x     = PIX_W'(px);
      beat.pixel_y     = PIX_W'(py);
      beat.pixel_valid = pv;
      beat.run_last    = last;
      beat.circle_done = done;
      pixel_queue.push_back(beat);
   endfunction

   // The eight mirror pixels of the current point, in the block's order.
   function automatic void push_mirrors(input logic done);
      int cx;
      int cy;
      int x;
      int y;
      cx = int'(held_cx);
      cy = int'(held_cy);
      x  = int'(trace_x);
      y  = int'(trace_y);
      push_pixel(cx + x, cy + y, 1'b1, 1'b0, 1'b0);
      push_pixel(cx - x, cy + y, 1'b1, 1'b0, 1'b0);
      push_pixel(cx + x, cy - y, 1'b1, 1'b0, 1'b0);
      push_pixel(cx - x, cy - y, 1'b1, 1'b0, 1'b0);
      push_pixel(cx + y, cy + x, 1'b1, 1'b0, 1'b0);
      push_pixel(cx - y, cy + x, 1'b1, 1'b0, 1'b0);
      push_pixel(cx + y, cy - x, 1'b1, 1'b0, 1'b0);
      push_pixel(cx - y, cy - x, 1'b1, 1'b1, done);
   endfunction

   // One accepted request beat: update the traced point and queue its pixels.
   function automatic void trace_circle(input logic op, input logic [COORD_BITS-1:0] cx,
                                        input logic [COORD_BITS-1:0] cy,
                                        input logic [COORD_BITS-1:0] rad);
      logic done;
      if (op == OP_START) begin
         held_cx        = cx;
         held_cy        = cy;
         trace_x        = '0;
         trace_y        = POS_W'(int'(rad));
         trace_decision = DEC_W'(INIT_BIAS - 2 * int'(rad));
         tracing        = 1'b1;
         push_mirrors(1'b0);
      end else if (!tracing) begin
         // Advance with no circle running: a single empty beat.
         push_pixel(0, 0, 1'b0, 1'b1, 1'b1);
      end else begin
         trace_x = POS_W'(int'(trace_x) + 1);
         if (trace_decision > 0) begin
            trace_y        = POS_W'(int'(trace_y) - 1);
            trace_decision = DEC_W'(int'(trace_decision)
                                    + 4 * (int'(trace_x) - int'(trace_y)) + STEP_BIAS_DIAG);
         end else begin
            trace_decision = DEC_W'(int'(trace_decision) + 4 * int'(trace_x)
                                    + STEP_BIAS_AXIS);
         end
         done = (trace_x > trace_y);
         push_mirrors(done);
         if (done) begin
            tracing = 1'b0;
         end
      end
   endfunction

   // Predict on request beats and compare on pixel beats.
   always @(posedge clock) begin
      pixel_beat_type seen;
      pixel_beat_type want;
      if (reset) begin
         pixel_queue.delete();
         trace_x        = '0;
         trace_y        = '0;
         trace_decision = '0;
         held_cx        = '0;
         held_cy        = '0;
         tracing        = 1'b0;
         fail_count     = 0;
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            trace_circle(req_mon.operation, req_mon.center_x, req_mon.center_y,
                         req_mon.radius);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            seen.pixel_x     = rsp_mon.pixel_x;
            seen.pixel_y     = rsp_mon.pixel_y;
            seen.pixel_valid = rsp_mon.pixel_valid;
            seen.run_last    = rsp_mon.run_last;
            seen.circle_done = rsp_mon.circle_done;
            if (pixel_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel beat (%0d, %0d)",
                                         seen.pixel_x, seen.pixel_y));
            end else begin
               want = pixel_queue.pop_front();
               if (seen.pixel_x !== want.pixel_x) begin
                  report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                            seen.pixel_x, want.pixel_x));
               end
               if (seen.pixel_y !== want.pixel_y) begin
                  report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                            seen.pixel_y, want.pixel_y));
               end
               if (seen.pixel_valid !== want.pixel_valid) begin
                  report_mismatch($sformatf("pixel_valid %b, expected %b",
                                            seen.pixel_valid, want.pixel_valid));
               end
               if (seen.run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %b, expected %b",
                                            seen.run_last, want.run_last));
               end
               if (seen.circle_done !== want.circle_done) begin
                  report_mismatch($sformatf("circle_done %b, expected %b",
                                            seen.circle_done, want.circle_done));
               end
            end
         end
      end
      pending_count <= pixel_queue.size();
   end

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

// Drives start and advance beats into the circle generator with random
// backpressure on both sides; the checker beside the block judges the pixels.
module tb;
   import crast_pkg::*;

   localparam int COORD_BITS  = COORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BEATS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   send_idle_pct = 28;
   int   recv_idle_pct = 81;
   int   sent_count = 0;
   int   fail_count;
   int   pending_count;

   crast_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   crast_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   circle_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   crast_checker #(.COORD_BITS(COORD_BITS)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Pixel sink with random stalls.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Sends one request beat, idling at random first; returns on acceptance.
   task automatic send_beat(input op_type op, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy,
                            input logic [COORD_BITS-1:0] rad);
      // Idling pattern follows the progress of the run.
      if (sent_count < 80) begin
         send_idle_pct = 28;
         recv_idle_pct = 81;
      end else if (sent_count < 150) begin
         send_idle_pct = 81;
         recv_idle_pct = 28;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.center_x  <= cx;
      req_chan.center_y  <= cy;
      req_chan.radius    <= rad;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      sent_count++;
   endtask

   task automatic send_advance();
      send_beat(OP_ADVANCE, COORD_BITS'($urandom_range(1023)),
                COORD_BITS'($urandom_range(1023)), COORD_BITS'($urandom_range(1023)));
   endtask

   initial begin
      int pick;
      int rad;
      int steps;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_START;
      req_chan.center_x  <= '0;
      req_chan.center_y  <= '0;
      req_chan.radius    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: advance with nothing running, then a zero radius circle.
      send_advance();
      send_beat(OP_START, 10'd0, 10'd0, 10'd0);
      send_advance();
      send_advance();
      // Largest radius at both corners; the second start drops the first circle.
      send_beat(OP_START, 10'd1023, 10'd1023, 10'd1023);
      send_advance();
      send_advance();
      send_beat(OP_START, 10'd0, 10'd1023, 10'd1023);
      send_advance();
      // Radius one finishes on its first advance.
      send_beat(OP_START, 10'd1023, 10'd0, 10'd1);
      send_advance();
      // A small circle traced to its end and two advances past it.
      send_beat(OP_START, 10'd512, 10'd341, 10'd5);
      repeat (6) send_advance();

      // Random: mostly complete circles, some cut short, some stray advances.
      sent_count = 0;
      while (sent_count < RANDOM_BEATS) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_advance();
         end else begin
            if (pick < 12) begin
               rad = $urandom_range(1023);
            end else begin
               rad = $urandom_range(24);
            end
            send_beat(OP_START, COORD_BITS'($urandom_range(1023)),
                      COORD_BITS'($urandom_range(1023)), COORD_BITS'(rad));
            steps = (rad * 3) / 4 + 2;
            if (steps > 40) begin
               steps = $urandom_range(40, 10);
            end
            if ($urandom_range(99) < 15) begin
               steps = $urandom_range(steps);
            end
            repeat (steps) send_advance();
         end
      end
      req_chan.valid <= 1'b0;

      // Drain, then leave time for any stray beat to show up.
      do begin
         @(posedge clock);
      end while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
